// ----- design/htsd_pkg.sv -----
// Shared types and constants for the Huffman trie stream decoder.
package htsd_pkg;

    localparam logic [3:0] HDR_SKIP_BYTES = 4'd4;
    localparam logic [3:0] HDR_LAST_BYTE  = 4'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] symbol;
        logic       run_end;
        logic       archive_done;
        logic       fault;
    } t_out;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_BIT,
        ST_LOAD,
        ST_FINISH,
        ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_CODE,
        PH_DECODE,
        PH_IDLE
    } t_phase;

    typedef struct packed {
        logic restart;
        logic hdr_cap;
        logic load_byte;
        logic len_shift;
        logic code_step;
        logic dec_step;
        logic load_cur;
        logic finish;
        logic emit_sym;
        logic emit_fault;
        logic bit_done;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic first_byte;
        logic hdr_last;
        logic last_bit;
        logic len_last;
        logic len_zero;
        logic child_zero;
        logic can_alloc;
        logic code_last;
        logic left_zero;
        logic leaf;
        logic tbl_last;
        logic total_zero;
        logic root_leaf;
        logic count_last;
        logic emit_ok;
        logic out_free;
        logic pend_valid;
    } t_status;

endpackage

// ----- design/htsd_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
module htsd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 511
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/htsd_dp.sv -----
// Datapath: byte and bit registers, header capture, trie storage, walk and result staging.
module htsd_dp #(
    parameter int NODE_COUNT   = 511,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htsd_pkg::t_in      i_in_data,
    input  htsd_pkg::t_cmd     i_cmd,
    output htsd_pkg::t_status  o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output htsd_pkg::t_out     o_out_data
);

    import htsd_pkg::*;

    localparam int NW     = $clog2(NODE_COUNT);
    localparam int FW     = $clog2(NODE_COUNT + 1);
    localparam int TW     = $clog2(SYMBOL_COUNT);
    localparam int NODE_W = 2 * NW + 8;

    typedef struct packed {
        logic [NW-1:0] left;
        logic [NW-1:0] right;
        logic [7:0]    sym;
    } t_node;

    logic [7:0]    r_byte,   n_byte;
    logic [2:0]    r_bcnt,   n_bcnt;
    logic [3:0]    r_hdr,    n_hdr;
    logic [63:0]   r_total,  n_total;
    logic [7:0]    r_lshift, n_lshift;
    logic [2:0]    r_lbits,  n_lbits;
    logic [7:0]    r_left,   n_left;
    logic [TW-1:0] r_tbl,    n_tbl;
    logic [FW-1:0] r_free,   n_free;
    logic [NW-1:0] r_walk,   n_walk;
    t_node         r_cur,    n_cur;
    t_node         r_root,   n_root;
    logic [63:0]   r_remain, n_remain;
    logic          r_pend_v, n_pend_v;
    t_out          r_pend,   n_pend;
    logic          r_out_v,  n_out_v;
    t_out          r_out,    n_out;

    logic              w_bit;
    logic [3:0]        w_hdr_idx;
    logic [2:0]        w_lane;
    logic [7:0]        w_len_next;
    logic [NW-1:0]     w_sel;
    t_node             w_par;
    t_node             w_rec;
    t_node             w_rnode;
    logic              w_out_free;
    logic              w_push;
    t_out              w_new;
    logic              w_we;
    logic [NW-1:0]     w_waddr;
    logic [NODE_W-1:0] w_wdata;
    logic              w_re;
    logic [NW-1:0]     w_raddr;
    logic [NODE_W-1:0] w_rdata;

    htsd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rnode    = t_node'(w_rdata);
    assign w_bit      = r_byte[7];
    assign w_hdr_idx  = i_in_data.first_byte ? 4'd0 : r_hdr;
    assign w_lane     = 3'(w_hdr_idx - HDR_SKIP_BYTES);
    assign w_len_next = {r_lshift[6:0], w_bit};
    assign w_sel      = w_bit ? r_cur.right : r_cur.left;
    assign w_out_free = !r_out_v || !i_out_stall;

    always_comb begin
        w_par = r_cur;
        if (w_bit) begin
            w_par.right = r_free[NW-1:0];
        end else begin
            w_par.left = r_free[NW-1:0];
        end
        w_rec     = r_cur;
        w_rec.sym = 8'(r_tbl);
    end

    always_comb begin
        o_status.first_byte = i_in_data.first_byte;
        o_status.hdr_last   = (w_hdr_idx == HDR_LAST_BYTE);
        o_status.last_bit   = (r_bcnt == 3'd0);
        o_status.len_last   = (r_lbits == 3'd7);
        o_status.len_zero   = (w_len_next == 8'd0);
        o_status.child_zero = (w_sel == '0);
        o_status.can_alloc  = (r_free < FW'(NODE_COUNT));
        o_status.code_last  = (r_left == 8'd1);
        o_status.left_zero  = (r_left == 8'd0);
        o_status.leaf       = (w_rnode.left == '0) && (w_rnode.right == '0);
        o_status.tbl_last   = (r_tbl == TW'(SYMBOL_COUNT - 1));
        o_status.total_zero = (r_total == 64'd0);
        o_status.root_leaf  = (r_root.left == '0) && (r_root.right == '0);
        o_status.count_last = (r_remain == 64'd1);
        o_status.emit_ok    = !r_pend_v || w_out_free;
        o_status.out_free   = w_out_free;
        o_status.pend_valid = r_pend_v;
    end

    always_comb begin
        n_byte   = r_byte;
        n_bcnt   = r_bcnt;
        n_hdr    = r_hdr;
        n_total  = r_total;
        n_lshift = r_lshift;
        n_lbits  = r_lbits;
        n_left   = r_left;
        n_tbl    = r_tbl;
        n_free   = r_free;
        n_walk   = r_walk;
        n_cur    = r_cur;
        n_root   = r_root;
        n_remain = r_remain;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out_v  = r_out_v && i_out_stall;
        n_out    = r_out;
        w_we     = 1'b0;
        w_waddr  = r_walk;
        w_wdata  = NODE_W'(w_par);
        w_re     = 1'b0;
        w_raddr  = w_sel;
        w_push   = 1'b0;
        w_new    = '0;

        if (i_cmd.restart) begin
            n_free   = FW'(1);
            n_walk   = '0;
            n_cur    = '0;
            n_root   = '0;
            n_tbl    = '0;
            n_lshift = '0;
            n_lbits  = '0;
        end
        if (i_cmd.hdr_cap) begin
            if (w_hdr_idx >= HDR_SKIP_BYTES) begin
                n_total[w_lane*8 +: 8] = i_in_data.data_byte;
            end
            n_hdr = w_hdr_idx + 4'd1;
        end
        if (i_cmd.load_byte) begin
            n_byte = i_in_data.data_byte;
            n_bcnt = 3'd7;
        end
        if (i_cmd.len_shift) begin
            n_lshift = w_len_next;
            n_lbits  = r_lbits + 3'd1;
            if (r_lbits == 3'd7) begin
                n_left = w_len_next;
            end
        end
        if (i_cmd.code_step) begin
            n_left = r_left - 8'd1;
            if (w_sel == '0) begin
                if (r_free < FW'(NODE_COUNT)) begin
                    if (r_walk == '0) begin
                        n_root = w_par;
                    end else begin
                        w_we = 1'b1;
                    end
                    n_walk = r_free[NW-1:0];
                    n_cur  = '0;
                    n_free = r_free + FW'(1);
                end
            end else begin
                n_walk = w_sel;
                w_re   = 1'b1;
            end
        end
        if (i_cmd.dec_step) begin
            n_walk = w_sel;
            w_re   = 1'b1;
        end
        if (i_cmd.load_cur) begin
            n_cur = w_rnode;
        end
        if (i_cmd.finish) begin
            w_wdata = NODE_W'(w_rec);
            if (r_walk == '0) begin
                n_root = w_rec;
                n_cur  = w_rec;
            end else begin
                w_we  = 1'b1;
                n_cur = r_root;
            end
            n_tbl    = r_tbl + TW'(1);
            n_walk   = '0;
            n_lbits  = '0;
            n_lshift = '0;
            n_remain = r_total;
        end
        if (i_cmd.emit_sym) begin
            w_push             = 1'b1;
            w_new.symbol       = w_rnode.sym;
            w_new.archive_done = (r_remain == 64'd1);
            n_remain           = r_remain - 64'd1;
            n_walk             = '0;
            n_cur              = r_root;
        end
        if (i_cmd.emit_fault) begin
            w_push      = 1'b1;
            w_new.fault = 1'b1;
        end
        if (w_push) begin
            if (r_pend_v) begin
                n_out         = r_pend;
                n_out.run_end = 1'b0;
                n_out_v       = 1'b1;
            end
            n_pend   = w_new;
            n_pend_v = 1'b1;
        end
        if (i_cmd.flush) begin
            n_out         = r_pend;
            n_out.run_end = 1'b1;
            n_out_v       = 1'b1;
            n_pend_v      = 1'b0;
        end
        if (i_cmd.bit_done) begin
            n_byte = {r_byte[6:0], 1'b0};
            n_bcnt = r_bcnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt   <= '0;
            r_hdr    <= '0;
            r_lshift <= '0;
            r_lbits  <= '0;
            r_tbl    <= '0;
            r_free   <= FW'(1);
            r_walk   <= '0;
            r_cur    <= '0;
            r_root   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_bcnt   <= n_bcnt;
            r_hdr    <= n_hdr;
            r_lshift <= n_lshift;
            r_lbits  <= n_lbits;
            r_tbl    <= n_tbl;
            r_free   <= n_free;
            r_walk   <= n_walk;
            r_cur    <= n_cur;
            r_root   <= n_root;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_byte   <= n_byte;
        r_total  <= n_total;
        r_left   <= n_left;
        r_remain <= n_remain;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ----- design/htsd_ctrl.sv -----
// Controller: archive phase and per-bit sequencing state machine.
module htsd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  htsd_pkg::t_status  i_status,
    output htsd_pkg::t_cmd     o_cmd
);

    import htsd_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_phase w_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCEPT;
            r_phase <= PH_HEADER;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_in_stall = (r_state != ST_ACCEPT);
    assign w_phase    = i_status.first_byte ? PH_HEADER : r_phase;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        unique case (r_state)
            ST_ACCEPT: begin
                if (i_in_valid) begin
                    o_cmd.restart = i_status.first_byte;
                    n_phase       = w_phase;
                    case (w_phase)
                        PH_HEADER: begin
                            o_cmd.hdr_cap = 1'b1;
                            if (i_status.hdr_last) begin
                                n_phase = PH_LENGTH;
                            end
                        end
                        PH_LENGTH, PH_CODE, PH_DECODE: begin
                            o_cmd.load_byte = 1'b1;
                            n_state         = ST_BIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BIT: begin
                case (r_phase)
                    PH_LENGTH: begin
                        o_cmd.len_shift = 1'b1;
                        if (i_status.len_last && i_status.len_zero) begin
                            n_state = ST_FINISH;
                        end else begin
                            if (i_status.len_last) begin
                                n_phase = PH_CODE;
                            end
                            o_cmd.bit_done = 1'b1;
                            n_state        = i_status.last_bit ? ST_FLUSH : ST_BIT;
                        end
                    end
                    PH_CODE: begin
                        o_cmd.code_step = 1'b1;
                        if (!i_status.child_zero) begin
                            n_state = ST_LOAD;
                        end else if (i_status.code_last) begin
                            n_state = ST_FINISH;
                        end else begin
                            o_cmd.bit_done = 1'b1;
                            n_state        = i_status.last_bit ? ST_FLUSH : ST_BIT;
                        end
                    end
                    PH_DECODE: begin
                        if (!i_status.child_zero) begin
                            o_cmd.dec_step = 1'b1;
                            n_state        = ST_LOAD;
                        end else if (i_status.emit_ok) begin
                            o_cmd.emit_fault = 1'b1;
                            o_cmd.bit_done   = 1'b1;
                            n_phase          = PH_IDLE;
                            n_state          = ST_FLUSH;
                        end
                    end
                    default: begin
                        n_state = ST_FLUSH;
                    end
                endcase
            end
            ST_LOAD: begin
                if (r_phase == PH_CODE) begin
                    o_cmd.load_cur = 1'b1;
                    if (i_status.left_zero) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.bit_done = 1'b1;
                        n_state        = i_status.last_bit ? ST_FLUSH : ST_BIT;
                    end
                end else if (!i_status.leaf) begin
                    o_cmd.load_cur = 1'b1;
                    o_cmd.bit_done = 1'b1;
                    n_state        = i_status.last_bit ? ST_FLUSH : ST_BIT;
                end else if (i_status.emit_ok) begin
                    o_cmd.emit_sym = 1'b1;
                    o_cmd.bit_done = 1'b1;
                    if (i_status.count_last) begin
                        n_phase = PH_IDLE;
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = i_status.last_bit ? ST_FLUSH : ST_BIT;
                    end
                end
            end
            ST_FINISH: begin
                if (i_status.emit_ok) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.bit_done = 1'b1;
                    if (!i_status.tbl_last) begin
                        n_phase = PH_LENGTH;
                        n_state = i_status.last_bit ? ST_FLUSH : ST_BIT;
                    end else if (i_status.total_zero) begin
                        n_phase = PH_IDLE;
                        n_state = ST_FLUSH;
                    end else if (i_status.root_leaf) begin
                        o_cmd.emit_fault = 1'b1;
                        n_phase          = PH_IDLE;
                        n_state          = ST_FLUSH;
                    end else begin
                        n_phase = PH_DECODE;
                        n_state = i_status.last_bit ? ST_FLUSH : ST_BIT;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = ST_ACCEPT;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

endmodule

// ----- design/huffman_trie_stream_decoder.sv -----
// Top level of the Huffman trie stream decoder: controller, datapath and node memory.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall | t_in: data_byte, first_byte
//  out     | output    | o_out_valid/i_out_stall | t_out: symbol, run_end, archive_done, fault
//
// A header byte or an ignored byte is taken without stalling the input. A stream byte is
// accepted, then each bit passes through ST_BIT, with ST_LOAD where a code or decode bit
// waits for the node memory's registered read and ST_FINISH where a code ends, and the byte
// ends in ST_FLUSH, which releases its last result. Reset clears all control state; the node
// memory needs no clearing because only nodes allocated since the last first byte are read.
// A stalled output holds the block at its next result, and the input is stalled until the
// current byte is finished.
module huffman_trie_stream_decoder #(
    parameter int NODE_COUNT   = 511,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  htsd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output htsd_pkg::t_out o_out_data
);

    import htsd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    htsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    htsd_dp #(
        .NODE_COUNT   (NODE_COUNT),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/htsd_tb_pkg.sv -----
// Scoreboard class that predicts and checks the decoded symbols of the trie stream decoder.
package htsd_tb_pkg;
    import htsd_pkg::*;

    localparam int NODE_N      = 511;
    localparam int SYM_N       = 256;
    localparam int MAX_REPORTS = 10;

    class symbol_scoreboard;
        logic [8:0]  left_child  [NODE_N];
        logic [8:0]  right_child [NODE_N];
        logic [7:0]  node_symbol [NODE_N];
        logic [8:0]  free_node;
        logic [8:0]  walk_node;
        t_phase      phase;
        logic [3:0]  hdr_index;
        logic [63:0] symbol_total;
        logic [63:0] symbol_count;
        logic [8:0]  table_index;
        logic [7:0]  length_shift;
        logic [3:0]  length_bits;
        logic [7:0]  code_left;
        t_out        expected_q[$];
        int          failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            for (int n = 0; n < NODE_N; n++) begin
                left_child[n]  = '0;
                right_child[n] = '0;
                node_symbol[n] = '0;
            end
            free_node    = 9'd1;
            walk_node    = '0;
            phase        = PH_HEADER;
            hdr_index    = '0;
            symbol_total = '0;
            symbol_count = '0;
            table_index  = '0;
            length_shift = '0;
            length_bits  = '0;
            code_left    = '0;
        endfunction

        function bit is_leaf(logic [8:0] n);
            return left_child[n] == '0 && right_child[n] == '0;
        endfunction

        function void emit(logic [7:0] sym, logic done, logic flt);
            t_out res;
            res.symbol       = sym;
            res.run_end      = 1'b0;
            res.archive_done = done;
            res.fault        = flt;
            expected_q.push_back(res);
        endfunction

        function void finish_code();
            node_symbol[walk_node] = table_index[7:0];
            table_index++;
            walk_node    = '0;
            length_bits  = '0;
            length_shift = '0;
            if (table_index < SYM_N) begin
                phase = PH_LENGTH;
            end else if (symbol_total == '0) begin
                phase = PH_IDLE;
            end else if (is_leaf('0)) begin
                phase = PH_IDLE;
                emit(8'd0, 1'b0, 1'b1);
            end else begin
                phase = PH_DECODE;
            end
        endfunction

        function void take_bit(logic b);
            logic [8:0] child;
            case (phase)
                PH_LENGTH: begin
                    length_shift = {length_shift[6:0], b};
                    length_bits++;
                    if (length_bits == 4'd8) begin
                        code_left = length_shift;
                        walk_node = '0;
                        if (code_left == '0) finish_code();
                        else phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    child = b ? right_child[walk_node] : left_child[walk_node];
                    if (child == '0 && free_node < NODE_N) begin
                        child = free_node;
                        free_node++;
                        if (b) right_child[walk_node] = child;
                        else left_child[walk_node] = child;
                    end
                    if (child != '0) walk_node = child;
                    code_left--;
                    if (code_left == '0) finish_code();
                end
                PH_DECODE: begin
                    child = b ? right_child[walk_node] : left_child[walk_node];
                    if (child == '0) begin
                        phase = PH_IDLE;
                        emit(8'd0, 1'b0, 1'b1);
                    end else if (is_leaf(child)) begin
                        symbol_count++;
                        walk_node = '0;
                        if (symbol_count == symbol_total) begin
                            phase = PH_IDLE;
                            emit(node_symbol[child], 1'b1, 1'b0);
                        end else begin
                            emit(node_symbol[child], 1'b0, 1'b0);
                        end
                    end else begin
                        walk_node = child;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_input(t_in item);
            int start_size;
            if (item.first_byte) restart();
            if (phase == PH_HEADER) begin
                if (hdr_index >= HDR_SKIP_BYTES)
                    symbol_total[(hdr_index - HDR_SKIP_BYTES) * 8 +: 8] = item.data_byte;
                if (hdr_index == HDR_LAST_BYTE) begin
                    phase        = PH_LENGTH;
                    length_bits  = '0;
                    length_shift = '0;
                end
                hdr_index++;
                return;
            end
            start_size = expected_q.size();
            for (int b = 7; b >= 0; b--) take_bit(item.data_byte[b]);
            if (expected_q.size() > start_size)
                expected_q[expected_q.size() - 1].run_end = 1'b1;
        endfunction

        function void note_failure(string what, t_out want, t_out got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s: expected symbol %0d run_end %0b done %0b fault %0b, got symbol %0d run_end %0b done %0b fault %0b",
                         what, want.symbol, want.run_end, want.archive_done, want.fault,
                         got.symbol, got.run_end, got.archive_done, got.fault);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                note_failure("unexpected result", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.symbol !== want.symbol || got.run_end !== want.run_end ||
                got.archive_done !== want.archive_done || got.fault !== want.fault)
                note_failure("result mismatch", want, got);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level testbench for the trie stream decoder: archive stimulus, idling and checking.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import htsd_pkg::*;
    import htsd_tb_pkg::*;

    localparam int RANDOM_ITEMS   = 420;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_CODE       = 255;

    typedef enum int {
        ARC_NORMAL,
        ARC_RANDOM,
        ARC_ABSENT,
        ARC_DEGENERATE,
        ARC_ZERO,
        ARC_FULL
    } t_arc_kind;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    symbol_scoreboard symbol_sb;
    bit               stream_bits[$];
    t_in              archive_q[$];
    logic [254:0]     leaf_code[$];
    int               leaf_len[$];
    int               code_len[SYM_N];
    logic [254:0]     code_word[SYM_N];
    int               quiet_cycles = 0;
    int               hold_left    = 0;
    bit               hold_quiet   = 1'b0;
    bit               send_quiet   = 1'b0;
    int               items_sent   = 0;

    huffman_trie_stream_decoder #(
        .NODE_COUNT  (NODE_N),
        .SYMBOL_COUNT(SYM_N)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [254:0] rand_word();
        logic [254:0] w;
        for (int i = 0; i < MAX_CODE; i++) w[i] = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic void add_bits(logic [254:0] value, int count);
        for (int i = count - 1; i >= 0; i--) stream_bits.push_back(value[i]);
    endfunction

    function automatic void add_random_bits(int count);
        repeat (count) stream_bits.push_back(1'($urandom_range(0, 1)));
    endfunction

    function automatic void add_leaf_code(int idx);
        add_bits(leaf_code[idx], leaf_len[idx]);
    endfunction

    function automatic void clear_table();
        for (int s = 0; s < SYM_N; s++) begin
            code_len[s]  = 0;
            code_word[s] = '0;
        end
    endfunction

    // Complete prefix code grown by splitting randomly chosen leaves.
    function automatic void build_tree(int leaves, int max_depth);
        int           idx;
        logic [254:0] word;
        leaf_code.delete();
        leaf_len.delete();
        leaf_code.push_back('0);
        leaf_len.push_back(1);
        leaf_code.push_back(255'd1);
        leaf_len.push_back(1);
        while (leaf_len.size() < leaves) begin
            do idx = $urandom_range(0, leaf_len.size() - 1);
            while (leaf_len[idx] >= max_depth);
            word = leaf_code[idx] << 1;
            leaf_code[idx] = word;
            leaf_len[idx]++;
            leaf_code.push_back(word | 255'd1);
            leaf_len.push_back(leaf_len[idx]);
        end
    endfunction

    function automatic void assign_symbols();
        int order[SYM_N];
        int j;
        int t;
        clear_table();
        for (int s = 0; s < SYM_N; s++) order[s] = s;
        for (int s = SYM_N - 1; s > 0; s--) begin
            j        = $urandom_range(0, s);
            t        = order[s];
            order[s] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < leaf_len.size(); i++) begin
            code_len[order[i]]  = leaf_len[i];
            code_word[order[i]] = leaf_code[i];
        end
    endfunction

    function automatic void begin_archive(bit first_flag, logic [63:0] total);
        t_in item;
        archive_q.delete();
        stream_bits.delete();
        for (int i = 0; i <= HDR_LAST_BYTE; i++) begin
            item.first_byte = (i == 0) ? first_flag : 1'b0;
            if (i < HDR_SKIP_BYTES) item.data_byte = 8'($urandom);
            else item.data_byte = total[(i - HDR_SKIP_BYTES) * 8 +: 8];
            archive_q.push_back(item);
        end
    endfunction

    function automatic void add_table();
        for (int s = 0; s < SYM_N; s++) begin
            add_bits(code_len[s], 8);
            add_bits(code_word[s], code_len[s]);
        end
    endfunction

    function automatic void pack_stream(int extra);
        t_in item;
        while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
        item.first_byte = 1'b0;
        while (stream_bits.size() > 0) begin
            for (int b = 7; b >= 0; b--) item.data_byte[b] = stream_bits.pop_front();
            archive_q.push_back(item);
        end
        repeat (extra) begin
            item.data_byte = 8'($urandom);
            archive_q.push_back(item);
        end
    endfunction

    function automatic void make_archive(t_arc_kind kind, bit first_flag, int leaves,
                                         int decode_syms);
        logic [63:0]  total;
        logic [254:0] hole_code;
        int           hole_len;
        int           idx;
        case (kind)
            ARC_NORMAL: begin
                build_tree(leaves, leaves > 40 ? MAX_CODE : 16);
                assign_symbols();
                total = decode_syms - $urandom_range(0, decode_syms > 2 ? 2 : 0);
                begin_archive(first_flag, total);
                add_table();
                repeat (decode_syms) add_leaf_code($urandom_range(0, leaf_len.size() - 1));
                pack_stream($urandom_range(0, 3));
            end
            ARC_RANDOM: begin
                clear_table();
                for (int s = 0; s < SYM_N; s++) begin
                    if ($urandom_range(0, 9) < 3) begin
                        code_len[s]  = $urandom_range(0, 12);
                        code_word[s] = rand_word();
                    end
                end
                total = $urandom_range(1, 64);
                begin_archive(first_flag, total);
                add_table();
                add_random_bits(8 * $urandom_range(4, 24));
                pack_stream(0);
            end
            ARC_ABSENT: begin
                // One leaf is dropped so that its code walks into a missing child.
                build_tree(leaves < 3 ? 3 : leaves, 16);
                idx       = $urandom_range(0, leaf_len.size() - 1);
                hole_code = leaf_code[idx];
                hole_len  = leaf_len[idx];
                leaf_code.delete(idx);
                leaf_len.delete(idx);
                assign_symbols();
                begin_archive(first_flag, '1);
                add_table();
                repeat ($urandom_range(0, 6)) add_leaf_code($urandom_range(0, leaf_len.size() - 1));
                add_bits(hole_code, hole_len);
                pack_stream(2);
            end
            ARC_DEGENERATE: begin
                clear_table();
                total = {32'($urandom), 32'($urandom)} | 64'd1;
                begin_archive(first_flag, total);
                add_table();
                pack_stream(3);
            end
            ARC_ZERO: begin
                build_tree(leaves, 16);
                assign_symbols();
                begin_archive(first_flag, '0);
                add_table();
                add_random_bits(32);
                pack_stream(2);
            end
            default: begin
                // Two disjoint codes of the longest length use every node of the trie.
                clear_table();
                code_len[0]  = MAX_CODE;
                code_word[0] = rand_word();
                code_word[0][MAX_CODE - 1] = 1'b0;
                code_len[1]  = MAX_CODE;
                code_word[1] = rand_word();
                code_word[1][MAX_CODE - 1] = 1'b1;
                for (int s = 2; s < 8; s++) begin
                    code_len[s]  = $urandom_range(1, 20);
                    code_word[s] = rand_word();
                end
                begin_archive(first_flag, 64'd3);
                add_table();
                add_bits(code_word[0], MAX_CODE);
                add_bits(code_word[1], MAX_CODE);
                add_random_bits(16);
                pack_stream(1);
            end
        endcase
    endfunction

    task automatic send_byte(input t_in item);
        int gap;
        if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
        gap = pick_gap(send_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_archive(input int keep);
        for (int i = 0; i < keep; i++) send_byte(archive_q[i]);
        items_sent += keep;
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 199) == 0) hold_quiet = !hold_quiet;
            hold_left = pick_gap(hold_quiet);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) symbol_sb.note_input(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) symbol_sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL huffman_trie_stream_decoder");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_in       noise;
        int        keep;
        int        pick;
        t_arc_kind kind;
        symbol_sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first archive relies on the reset state alone, with no restart flag.
        make_archive(ARC_NORMAL, 1'b0, 2, 64);
        send_archive(archive_q.size());
        noise.first_byte = 1'b1;
        noise.data_byte  = 8'hFF;
        send_byte(noise);
        noise.data_byte  = 8'h00;
        send_byte(noise);
        noise.first_byte = 1'b0;
        noise.data_byte  = 8'h5A;
        send_byte(noise);
        make_archive(ARC_NORMAL, 1'b1, SYM_N, 48);
        send_archive(archive_q.size());
        make_archive(ARC_DEGENERATE, 1'b1, 2, 1);
        send_archive(archive_q.size());
        make_archive(ARC_ZERO, 1'b1, 12, 1);
        send_archive(archive_q.size());
        make_archive(ARC_ABSENT, 1'b1, 20, 1);
        send_archive(archive_q.size());
        make_archive(ARC_FULL, 1'b1, 2, 1);
        send_archive(archive_q.size());
        make_archive(ARC_RANDOM, 1'b1, 2, 1);
        send_archive(archive_q.size());

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) kind = ARC_NORMAL;
            else if (pick < 65) kind = ARC_RANDOM;
            else if (pick < 80) kind = ARC_ABSENT;
            else if (pick < 87) kind = ARC_FULL;
            else if (pick < 94) kind = ARC_DEGENERATE;
            else kind = ARC_ZERO;
            make_archive(kind, 1'b1, $urandom_range(2, 40), $urandom_range(1, 48));
            keep = archive_q.size();
            if ($urandom_range(0, 99) < 12) keep = $urandom_range(1, keep - 1);
            send_archive(keep);
            if ($urandom_range(0, 3) == 0) begin
                noise.first_byte = 1'b0;
                repeat ($urandom_range(1, 4)) begin
                    noise.data_byte = 8'($urandom);
                    send_byte(noise);
                end
            end
        end
        i_in_valid <= 1'b0;

        while (symbol_sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (symbol_sb.failures == 0) begin
            $display("PASS huffman_trie_stream_decoder");
        end else begin
            $display("FAIL huffman_trie_stream_decoder");
        end
        $finish;
    end

endmodule
